// File: hw/rtl/mbss_pkg.sv
`default_nettype none

package mbss_pkg;

    // Signature storage is fixed by the register map: three 64-bit words of bytes.
    localparam int SIG_BYTES   = 24;
    localparam int LEN_W       = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ADDR_W      = 32;
    localparam int SEEN_W      = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_MID  = 3'd1,
        REG_PATTERN_HIGH = 3'd2,
        REG_CARE_MASK    = 3'd3,
        REG_PATTERN_LEN  = 3'd4,
        REG_SCAN_BASE    = 3'd5
    } reg_index_t;

    // Programmed signature and region setup.
    typedef struct packed {
        logic [63:0]          pattern_low;
        logic [63:0]          pattern_mid;
        logic [63:0]          pattern_high;
        logic [SIG_BYTES-1:0] care_mask;
        logic [LEN_W-1:0]     pattern_length;
        logic [ADDR_W-1:0]    scan_base;
    } cfg_t;

    // One search result.
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/mbss_channels.sv
`default_nettype none

// Byte stream channel.
interface mbss_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Search result channel.
interface mbss_result_if;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [mbss_pkg::ADDR_W-1:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink (input valid, input found, input match_address, output ready);
endinterface

// Configuration write channel.
interface mbss_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mbss_pkg::CFG_INDEX_W-1:0] index;
    logic [mbss_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mbss_ram.sv
`default_nettype none

module mbss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port returning the old data on a collision.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/mbss_result_queue.sv
`default_nettype none

module mbss_result_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mbss_pkg::result_t push_data,
    output logic                   full,
    mbss_result_if.source          result
);

    mbss_pkg::result_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              pop;

    // The head entry drives the result channel.
    assign result.valid         = (count_reg != 2'd0);
    assign result.found         = entry_reg[rd_ptr_reg].found;
    assign result.match_address = entry_reg[rd_ptr_reg].match_address;
    assign pop                  = result.valid && result.ready;
    assign full                 = (count_reg == 2'd2);

    // Occupancy follows pushes and pops in the same cycle.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mbss_scan_core.sv
`default_nettype none

module mbss_scan_core #(
    parameter int PATTERN_MAX = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire mbss_pkg::cfg_t    cfg,
    output logic                   push,
    output mbss_pkg::result_t      push_data
);

    localparam int WIN_W   = PATTERN_MAX * 8;
    localparam int STATE_W = WIN_W + mbss_pkg::SEEN_W + 1;

    logic [STATE_W-1:0] ram_rdata;
    logic [STATE_W-1:0] fwd_data_reg;
    logic               fwd_valid_reg;
    logic               init_reg;
    logic [STATE_W-1:0] state_cur;
    logic [STATE_W-1:0] state_next;

    logic [PATTERN_MAX-1:0][7:0]     win_cur;
    logic [PATTERN_MAX-1:0][7:0]     win_new;
    logic [PATTERN_MAX-1:0][7:0]     win_next;
    logic [mbss_pkg::SEEN_W-1:0]     seen_cur;
    logic [mbss_pkg::SEEN_W-1:0]     seen_new;
    logic [mbss_pkg::SEEN_W-1:0]     seen_next;
    logic                            done_cur;
    logic                            done_next;

    logic [mbss_pkg::SIG_BYTES-1:0][7:0] sig;
    logic [mbss_pkg::LEN_W-1:0]          ulen;
    logic [mbss_pkg::LEN_W-1:0]          k;
    logic [PATTERN_MAX-1:0][7:0]         asig;
    logic [PATTERN_MAX-1:0]              acare;
    logic [PATTERN_MAX-1:0]              byte_ok;
    logic                                hit;
    logic [mbss_pkg::ADDR_W-1:0]         addr;

    // Region state lives in a one-entry memory, rewritten on every transfer.
    mbss_ram #(
        .WIDTH (STATE_W),
        .DEPTH (1)
    ) u_state_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (1'b0),
        .wdata (state_next),
        .raddr (1'b0),
        .rdata (ram_rdata)
    );

    // The memory read is registered, so the last written state is forwarded.
    // Before the first write the memory holds nothing and the state reads as cleared.
    always_comb
    begin
        if (fwd_valid_reg)
        begin
            state_cur = fwd_data_reg;
        end
        else if (init_reg)
        begin
            state_cur = ram_rdata;
        end
        else
        begin
            state_cur = '0;
        end
    end

    assign win_cur  = state_cur[WIN_W-1:0];
    assign seen_cur = state_cur[WIN_W +: mbss_pkg::SEEN_W];
    assign done_cur = state_cur[STATE_W-1];

    // Shift the new byte into the window and count it, saturating at all ones.
    assign win_new  = {win_cur[PATTERN_MAX-2:0], data_byte};
    assign seen_new = (seen_cur == '1) ? seen_cur : seen_cur + mbss_pkg::SEEN_W'(1);

    // Effective signature length: zero acts as one; clamped to stored bytes and window.
    always_comb
    begin
        ulen = cfg.pattern_length;
        if (ulen == '0)
        begin
            ulen = mbss_pkg::LEN_W'(1);
        end
        if (ulen > mbss_pkg::LEN_W'(mbss_pkg::SIG_BYTES))
        begin
            ulen = mbss_pkg::LEN_W'(mbss_pkg::SIG_BYTES);
        end
        if (int'(ulen) > PATTERN_MAX)
        begin
            ulen = mbss_pkg::LEN_W'(PATTERN_MAX);
        end
    end

    assign sig = {cfg.pattern_high, cfg.pattern_mid, cfg.pattern_low};

    // Align the signature to window positions: the newest byte meets the last signature byte.
    always_comb
    begin
        k = '0;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            asig[j]  = 8'h00;
            acare[j] = 1'b0;
            if (j < int'(ulen))
            begin
                k        = mbss_pkg::LEN_W'(int'(ulen) - 1 - j);
                asig[j]  = sig[k];
                acare[j] = cfg.care_mask[k];
            end
        end
    end

    // Parallel masked compare of the whole window.
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            byte_ok[j] = !acare[j] || (win_new[j] == asig[j]);
        end
    end

    assign hit  = (&byte_ok) && (seen_new >= mbss_pkg::SEEN_W'(ulen));
    assign addr = cfg.scan_base + seen_new - mbss_pkg::ADDR_W'(ulen);

    // One result per region: the first match, or not found at the last byte.
    assign push                    = accept && !done_cur && (hit || last_byte);
    assign push_data.found         = hit;
    assign push_data.match_address = hit ? addr : '0;

    // The last byte of a region clears the whole state.
    assign win_next   = last_byte ? '0 : win_new;
    assign seen_next  = last_byte ? '0 : seen_new;
    assign done_next  = last_byte ? 1'b0 : (done_cur || hit);
    assign state_next = {done_next, seen_next, win_next};

    // Forwarding control and the written-once flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            init_reg      <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= accept;
            if (accept)
            begin
                init_reg <= 1'b1;
            end
        end
    end

    // Forwarded copy of the last write.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/masked_byte_signature_scan_unit.sv
`default_nettype none
// Results: a result is pushed into a two-entry result queue when the byte that causes it
// is transferred, and the queue offers its head entry on the result channel.
// Throughput: one byte per cycle; the byte channel stalls only when the result queue is full.
// Reset: configuration returns to its reset values, the region state reads as cleared
// until its memory entry is first written, and the result queue empties.

module masked_byte_signature_scan_unit #(
    parameter int PATTERN_MAX = 24
) (
    input wire logic     clk,
    input wire logic     rst_n,
    mbss_scan_if.sink    bytes,
    mbss_result_if.source result,
    mbss_cfg_if.sink     cfg
);

    mbss_pkg::cfg_t    cfg_reg;
    mbss_pkg::result_t push_data;
    logic              push;
    logic              full;
    logic              accept;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_mid    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.care_mask      <= '0;
            cfg_reg.pattern_length <= mbss_pkg::LEN_W'(1);
            cfg_reg.scan_base      <= '0;
        end
        else if (cfg.valid)
        begin
            case (mbss_pkg::reg_index_t'(cfg.index))
                mbss_pkg::REG_PATTERN_LOW:  cfg_reg.pattern_low    <= cfg.data;
                mbss_pkg::REG_PATTERN_MID:  cfg_reg.pattern_mid    <= cfg.data;
                mbss_pkg::REG_PATTERN_HIGH: cfg_reg.pattern_high   <= cfg.data;
                mbss_pkg::REG_CARE_MASK:
                    cfg_reg.care_mask <= cfg.data[mbss_pkg::SIG_BYTES-1:0];
                mbss_pkg::REG_PATTERN_LEN:
                    cfg_reg.pattern_length <= cfg.data[mbss_pkg::LEN_W-1:0];
                mbss_pkg::REG_SCAN_BASE:
                    cfg_reg.scan_base <= cfg.data[mbss_pkg::ADDR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A byte transfer needs room for a possible result.
    assign bytes.ready = !full;
    assign accept      = bytes.valid && bytes.ready;

    mbss_scan_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (bytes.data_byte),
        .last_byte (bytes.last_byte),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data)
    );

    mbss_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .result    (result)
    );

endmodule

`default_nettype wire

// File: bench/tb_masked_byte_signature_scan_unit.sv
`timescale 1ns / 100ps

module tb_masked_byte_signature_scan_unit;

    localparam int PATTERN_MAX   = 24;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TARGET_BYTES  = 1500;
    localparam int PRESSURE_PHASE = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mbss_scan_if   scan_ch();
    mbss_result_if result_ch();
    mbss_cfg_if    cfg_ch();

    masked_byte_signature_scan_unit #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (scan_ch),
        .result(result_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    // Bytes waiting for the driver and search reports waiting for the block.
    stream_byte_t      byte_feed[$];
    mbss_pkg::result_t awaited_reports[$];
    int                bytes_queued = 0;
    int                bytes_taken  = 0;
    int                mismatches   = 0;
    int                cycle_count  = 0;

    // Idling control shared between the stimulus and the two channel processes.
    bit idle_mode  = 1'b0;
    int hold_seq   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_left = 0;
    int send_gap   = 0;
    bit byte_moved = 1'b0;

    // Predicted block state: registers and the current region.
    logic [8*mbss_pkg::SIG_BYTES-1:0] model_sig  = '0;
    logic [mbss_pkg::SIG_BYTES-1:0]   model_care = '0;
    logic [mbss_pkg::LEN_W-1:0]       model_len  = mbss_pkg::LEN_W'(1);
    logic [mbss_pkg::ADDR_W-1:0]      model_base = '0;
    logic [7:0]                       region_window [PATTERN_MAX] = '{default: 8'h00};
    logic [mbss_pkg::SEEN_W-1:0]      region_seen = '0;
    logic                             region_done = 1'b0;

    // Signature currently programmed, as seen by the stimulus generator.
    logic [8*mbss_pkg::SIG_BYTES-1:0] cur_sig;
    logic [mbss_pkg::SIG_BYTES-1:0]   cur_care;
    int                               cur_len;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Shift one byte into the region window and queue the report it causes, if any.
    function automatic void scan_step(input logic [7:0] b, input logic last);
        int                len;
        bit                hit;
        mbss_pkg::result_t rep;
        for (int i = PATTERN_MAX - 1; i > 0; i--)
            region_window[i] = region_window[i - 1];
        region_window[0] = b;
        if (region_seen != '1)
            region_seen++;
        if (!region_done)
        begin
            len = (model_len == 0) ? 1 : int'(model_len);
            if (len > mbss_pkg::SIG_BYTES)
                len = mbss_pkg::SIG_BYTES;
            if (len > PATTERN_MAX)
                len = PATTERN_MAX;
            hit = 1'b0;
            if (region_seen >= mbss_pkg::SEEN_W'(len))
            begin
                hit = 1'b1;
                for (int i = 0; i < len; i++)
                    if (model_care[i] && region_window[len - 1 - i] != model_sig[8*i +: 8])
                        hit = 1'b0;
            end
            if (hit)
            begin
                region_done       = 1'b1;
                rep.found         = 1'b1;
                rep.match_address = model_base + region_seen - mbss_pkg::ADDR_W'(len);
                awaited_reports.push_back(rep);
            end
            else if (last)
            begin
                rep.found         = 1'b0;
                rep.match_address = '0;
                awaited_reports.push_back(rep);
            end
        end
        // The last byte closes the region.
        if (last)
        begin
            foreach (region_window[k])
                region_window[k] = 8'h00;
            region_seen = '0;
            region_done = 1'b0;
        end
    endfunction

    // Sample every transfer at the rising edge and keep the prediction in step.
    always @(posedge clk)
    begin
        mbss_pkg::result_t want;
        byte_moved = 1'b0;
        if (rst_n)
        begin
            cycle_count++;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    mbss_pkg::REG_PATTERN_LOW:  model_sig[63:0]    = cfg_ch.data;
                    mbss_pkg::REG_PATTERN_MID:  model_sig[127:64]  = cfg_ch.data;
                    mbss_pkg::REG_PATTERN_HIGH: model_sig[191:128] = cfg_ch.data;
                    mbss_pkg::REG_CARE_MASK:
                        model_care = cfg_ch.data[mbss_pkg::SIG_BYTES-1:0];
                    mbss_pkg::REG_PATTERN_LEN:
                        model_len  = cfg_ch.data[mbss_pkg::LEN_W-1:0];
                    mbss_pkg::REG_SCAN_BASE:
                        model_base = cfg_ch.data[mbss_pkg::ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (scan_ch.valid && scan_ch.ready)
            begin
                byte_moved = 1'b1;
                bytes_taken++;
                scan_step(scan_ch.data_byte, scan_ch.last_byte);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("result with none pending: found=%0b match_address=%h",
                           result_ch.found, result_ch.match_address);
                    mismatches++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (result_ch.found !== want.found)
                    begin
                        $error("found: expected %0b, actual %0b", want.found, result_ch.found);
                        mismatches++;
                    end
                    if (result_ch.match_address !== want.match_address)
                    begin
                        $error("match_address: expected %h, actual %h",
                               want.match_address, result_ch.match_address);
                        mismatches++;
                    end
                end
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Byte driver: a new byte goes out once the previous one has transferred.
    always @(negedge clk)
    begin
        stream_byte_t next_item;
        if (rst_n && (!scan_ch.valid || byte_moved))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                scan_ch.valid <= 1'b0;
            end
            else if (byte_feed.size() != 0)
            begin
                next_item = byte_feed.pop_front();
                scan_ch.valid     <= 1'b1;
                scan_ch.data_byte <= next_item.data;
                scan_ch.last_byte <= next_item.last;
                send_gap = (idle_mode && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
            else
                scan_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus a long hold-off when the stimulus asks.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (idle_mode && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic write_register(input mbss_pkg::reg_index_t idx,
                                  input logic [mbss_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready))
            @(posedge clk);
    endtask

    // Write every register; only called while the block is idle.
    task automatic program_signature(input logic [63:0] lo, input logic [63:0] mid,
                                     input logic [63:0] hi, input logic [63:0] care_word,
                                     input logic [63:0] len_word, input logic [63:0] base_word);
        cur_sig  = {hi, mid, lo};
        cur_care = care_word[mbss_pkg::SIG_BYTES-1:0];
        cur_len  = int'(len_word[mbss_pkg::LEN_W-1:0]);
        if (cur_len == 0)
            cur_len = 1;
        if (cur_len > mbss_pkg::SIG_BYTES)
            cur_len = mbss_pkg::SIG_BYTES;
        write_register(mbss_pkg::REG_PATTERN_LOW, lo);
        write_register(mbss_pkg::REG_PATTERN_MID, mid);
        write_register(mbss_pkg::REG_PATTERN_HIGH, hi);
        write_register(mbss_pkg::REG_CARE_MASK, care_word);
        write_register(mbss_pkg::REG_PATTERN_LEN, len_word);
        write_register(mbss_pkg::REG_SCAN_BASE, base_word);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last);
        stream_byte_t item;
        item.data = data;
        item.last = last;
        byte_feed.push_back(item);
        bytes_queued++;
    endtask

    // Hold the sender until every byte has transferred and every report has come.
    task automatic drain();
        @(negedge clk);
        while (bytes_taken != bytes_queued || awaited_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One region: noise mixed with signature bytes, an optional near miss,
    // and an optional planted signature with random skipped bytes.
    task automatic queue_region(input int span, input bit plant, input bit decoy);
        logic [7:0] region [$];
        int         at;
        int         pick;
        for (int k = 0; k < span; k++)
        begin
            pick = $urandom_range(0, cur_len - 1);
            region.push_back($urandom_range(0, 1) ? 8'($urandom) : cur_sig[8*pick +: 8]);
        end
        if (span >= cur_len && decoy)
        begin
            at = $urandom_range(0, span - cur_len);
            for (int j = 0; j < cur_len; j++)
                if (cur_care[j])
                    region[at + j] = cur_sig[8*j +: 8];
            pick = $urandom_range(0, cur_len - 1);
            if (cur_care[pick])
                region[at + pick] = region[at + pick] ^ 8'($urandom_range(1, 255));
        end
        if (span >= cur_len && plant)
        begin
            at = $urandom_range(0, span - cur_len);
            for (int j = 0; j < cur_len; j++)
                if (cur_care[j])
                    region[at + j] = cur_sig[8*j +: 8];
        end
        for (int k = 0; k < span; k++)
            push_byte(region[k], k == span - 1);
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        int          phase;
        int          span;
        int          len_raw;
        logic [23:0] care;
        logic [31:0] base;
        scan_ch.valid     = 1'b0;
        scan_ch.data_byte = 8'h00;
        scan_ch.last_byte = 1'b0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = mbss_pkg::REG_PATTERN_LOW;
        cfg_ch.data       = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        idle_mode = 1'b1;

        // Reset settings: one position, skipped, so every region matches at once;
        // the bytes after a match stay silent and a match may land on the last byte.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hA5, 1'b1);
        drain();

        // Four positions with a skipped third byte; a near miss first, then a
        // match whose address wraps past the top of the address space.
        program_signature(64'h0000_0000_EF00_ADDE, '1, 64'h0123_4567_89AB_CDEF,
                          64'hFFFF_FFFF_FF00_000B, 64'hFFFF_FFFF_FFFF_FFE4,
                          64'hA5A5_A5A5_FFFF_FFFE);
        push_byte(8'hDE, 1'b0);
        push_byte(8'hAD, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hDE, 1'b0);
        push_byte(8'hAD, 1'b0);
        push_byte(8'h77, 1'b0);
        push_byte(8'hEF, 1'b1);
        // A region without the signature, then one too short to hold it.
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b1);
        push_byte(8'hDE, 1'b0);
        push_byte(8'hAD, 1'b0);
        push_byte(8'hEF, 1'b1);
        drain();

        // A length of zero acts as one.
        program_signature(64'h5A, '0, '1, 64'h1234_5678_9AFF_FFFF, 64'hE0,
                          64'h0000_0000_0040_0000);
        push_byte(8'h5A, 1'b1);
        push_byte(8'h00, 1'b1);
        drain();

        // Random phases, each with its own settings.
        phase = 0;
        while (bytes_queued < TARGET_BYTES)
        begin
            case ($urandom_range(0, 7))
                0: len_raw = 0;
                1: len_raw = 1;
                2: len_raw = mbss_pkg::SIG_BYTES;
                3: len_raw = $urandom_range(mbss_pkg::SIG_BYTES + 1, 31);
                7: len_raw = $urandom_range(1, mbss_pkg::SIG_BYTES);
                default: len_raw = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 5))
                0: care = '0;
                1: care = '1;
                default: care = 24'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: base = '0;
                1: base = '1;
                2: base = 32'hFFFF_FFF0;
                default: base = $urandom;
            endcase
            if (phase == 0)
            begin
                len_raw = 31;
                care    = '1;
            end
            else if (phase == 1)
            begin
                len_raw = mbss_pkg::SIG_BYTES;
                care    = '0;
                base    = '1;
            end
            else if (phase == PRESSURE_PHASE)
            begin
                len_raw = 1;
                care    = '0;
            end
            program_signature(pick_word(), pick_word(), pick_word(),
                              {$urandom, 8'($urandom), care},
                              {$urandom, 27'($urandom), 5'(len_raw)},
                              {$urandom, base});

            if (phase == PRESSURE_PHASE)
            begin
                // Every byte ends a region and reports; the receiver holds off
                // while the sender keeps offering, so the block backs up.
                idle_mode = 1'b0;
                hold_seq++;
                for (int r = 0; r < 40; r++)
                    push_byte(8'($urandom), 1'b1);
            end
            else
            begin
                idle_mode = ($urandom_range(0, 3) != 0);
                for (int r = $urandom_range(6, 10); r > 0; r--)
                begin
                    case ($urandom_range(0, 9))
                        0: span = $urandom_range(1, cur_len);
                        1: span = $urandom_range(cur_len, cur_len + 48);
                        default: span = cur_len + $urandom_range(0, 10);
                    endcase
                    queue_region(span, $urandom_range(0, 4) != 0, $urandom_range(0, 2) == 0);
                end
            end
            drain();
            phase++;
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
